>>> sv/msd_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the multi-switch counting debouncer.
// No dependencies; used by every module of the block.

package msd_pkg;

    localparam int unsigned MAX_SWITCHES     = 16;
    localparam int unsigned NUM_SWITCHES_DEF = 16;
    localparam int unsigned INDEX_W          = 8;
    localparam int unsigned COUNT_W          = 8;
    localparam int unsigned MASK_W           = MAX_SWITCHES;
    localparam int unsigned CFG_INDEX_W      = 2;
    localparam int unsigned CFG_DATA_W       = 16;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT_RESET = COUNT_W'(10);
    localparam logic [MASK_W-1:0]  MASK_RESET        = '0;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_COUNT_LIMIT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LEVEL_MASK  = CFG_INDEX_W'(1);

    // Result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    typedef struct packed {
        logic [INDEX_W-1:0] switch_index;
        logic               pin_level;
    } sample_t;

    typedef struct packed {
        logic status;
        logic pressed;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count_limit;
        logic [MASK_W-1:0]  pressed_level_mask;
    } cfg_t;

endpackage

>>> sv/msd_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration registers of the debouncer: count limit and pressed-level mask.
// Depends on msd_pkg.

module msd_cfg_regs
    import msd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    logic [COUNT_W-1:0] count_limit_reg;
    logic [MASK_W-1:0]  level_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_limit_reg <= COUNT_LIMIT_RESET;
            level_mask_reg  <= MASK_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_IDX_COUNT_LIMIT: count_limit_reg <= cfg_data[COUNT_W-1:0];
                CFG_IDX_LEVEL_MASK:  level_mask_reg  <= cfg_data[MASK_W-1:0];
                default:             ;
            endcase
        end
    end

    assign cfg.count_limit        = count_limit_reg;
    assign cfg.pressed_level_mask = level_mask_reg;

endmodule

>>> sv/msd_switch_bank.sv
`timescale 1ns / 1ps
// Per-switch debounce state and the single-pass update for one sample word.
// Depends on msd_pkg.

module msd_switch_bank
    import msd_pkg::*;
#(
    parameter int unsigned NUM_SWITCHES = NUM_SWITCHES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    commit,
    input  sample_t sample,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int unsigned IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

    logic               stable_reg   [NUM_SWITCHES];
    logic               bouncing_reg [NUM_SWITCHES];
    logic [COUNT_W-1:0] press_cnt_reg [NUM_SWITCHES];
    logic [COUNT_W-1:0] rel_cnt_reg   [NUM_SWITCHES];

    logic               stable_next;
    logic               bouncing_next;
    logic [COUNT_W-1:0] press_cnt_next;
    logic [COUNT_W-1:0] rel_cnt_next;

    logic [IDX_W-1:0]   sel;
    logic               in_range;
    logic               is_press;
    logic               report;

    assign sel      = sample.switch_index[IDX_W-1:0];
    assign in_range = (sample.switch_index < INDEX_W'(NUM_SWITCHES));
    assign is_press = (sample.pin_level == cfg.pressed_level_mask[sel]);

    always_comb
    begin
        stable_next    = stable_reg[sel];
        bouncing_next  = bouncing_reg[sel];
        press_cnt_next = press_cnt_reg[sel];
        rel_cnt_next   = rel_cnt_reg[sel];
        report         = stable_reg[sel];

        if (bouncing_reg[sel])
        begin
            // count the run; the other counter starts over
            if (is_press)
            begin
                press_cnt_next = press_cnt_reg[sel] + COUNT_W'(1);
                rel_cnt_next   = '0;
            end
            else
            begin
                rel_cnt_next   = rel_cnt_reg[sel] + COUNT_W'(1);
                press_cnt_next = '0;
            end
            // pressed run is tested first
            if (press_cnt_next == cfg.count_limit)
            begin
                press_cnt_next = '0;
                bouncing_next  = 1'b0;
                stable_next    = 1'b1;
            end
            else if (rel_cnt_next == cfg.count_limit)
            begin
                rel_cnt_next  = '0;
                bouncing_next = 1'b0;
                stable_next   = 1'b0;
            end
            report = stable_next;
        end
        else if (is_press != stable_reg[sel])
        begin
            bouncing_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SWITCHES; i++)
            begin
                stable_reg[i]    <= 1'b0;
                bouncing_reg[i]  <= 1'b0;
                press_cnt_reg[i] <= '0;
                rel_cnt_reg[i]   <= '0;
            end
        end
        else if (commit && in_range)
        begin
            stable_reg[sel]    <= stable_next;
            bouncing_reg[sel]  <= bouncing_next;
            press_cnt_reg[sel] <= press_cnt_next;
            rel_cnt_reg[sel]   <= rel_cnt_next;
        end
    end

    assign result.status  = in_range ? STATUS_OK : STATUS_BAD_INDEX;
    assign result.pressed = in_range & report;

endmodule

>>> sv/multi_switch_counting_debouncer_unit.sv
`timescale 1ns / 1ps
// Top level of the multi-switch counting debouncer: input and result registers.
// Depends on msd_pkg, msd_cfg_regs and msd_switch_bank.
//
//   channel   direction  handshake                  word
//   sample    in         sample_valid/sample_stall  sample_t (switch_index, pin_level)
//   result    out        result_valid/result_stall  result_t (status, pressed)
//   cfg       in         cfg_wr_en                  cfg_index, cfg_data
//
// Each sample word passes through the input register and then the result
// register. A new word is accepted every cycle unless the result is stalled.
// State is updated as the result is registered, so back-to-back samples of one
// switch see each other's effect. Reset clears all switch state to released.
// A stalled result holds the input register; sample_stall rises only then.

module multi_switch_counting_debouncer_unit
    import msd_pkg::*;
#(
    parameter int unsigned NUM_SWITCHES = NUM_SWITCHES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  sample_t                sample,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    result_t bank_result;

    logic    in_valid_reg;
    sample_t in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;

    logic    out_free;
    logic    advance;

    assign out_free     = !out_valid_reg || !result_stall;
    assign advance      = in_valid_reg && out_free;
    assign sample_stall = in_valid_reg && !out_free;

    msd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msd_switch_bank #(
        .NUM_SWITCHES (NUM_SWITCHES)
    ) u_switch_bank
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .sample (in_data_reg),
        .cfg    (cfg),
        .result (bank_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!sample_stall)
            begin
                in_valid_reg <= sample_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!sample_stall && sample_valid)
        begin
            in_data_reg <= sample;
        end
        if (advance)
        begin
            out_data_reg <= bank_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid && result_stall))
        else $error("sample stalled while result register free");

    a_result_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(in_valid_reg))
        else $error("result appeared without a registered sample");

    a_error_not_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (bank_result.status == STATUS_BAD_INDEX)) |=> !result.pressed)
        else $error("out-of-range sample reported pressed");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for multi_switch_counting_debouncer_unit: directed and random
// sample words, predicted per switch and compared word by word. Depends on msd_pkg.

module tb_top;
    import msd_pkg::*;

    localparam int unsigned NUM_SW         = NUM_SWITCHES_DEF;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_OFF_LEN   = 150;
    localparam int unsigned DRAIN_CYCLES   = 4;

    // Indexes that decode to no register
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_LO = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_HI = CFG_INDEX_W'(3);

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   sample_valid;
    logic                   sample_stall;
    sample_t                sample;
    logic                   result_valid;
    logic                   result_stall;
    result_t                result;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Debouncer state as the bench expects it
    logic               sw_stable    [MAX_SWITCHES];
    logic               sw_bouncing  [MAX_SWITCHES];
    logic [COUNT_W-1:0] sw_press_cnt [MAX_SWITCHES];
    logic [COUNT_W-1:0] sw_rel_cnt   [MAX_SWITCHES];
    logic [COUNT_W-1:0] model_limit;
    logic [MASK_W-1:0]  model_mask;

    result_t     expected_results[$];
    result_t     want;
    int unsigned n_sent;
    int unsigned n_fail;
    int unsigned idle_cycles;
    int unsigned hold_off_len;
    bit          tx_idle_on;
    bit          rx_idle_on;

    multi_switch_counting_debouncer_unit #(
        .NUM_SWITCHES (NUM_SW)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned rand_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index(input int unsigned lo,
                                                      input int unsigned hi);
        return INDEX_W'($urandom_range(lo, hi));
    endfunction

    function automatic logic rand_level();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic result_t debounce_predict(input sample_t s);
        result_t     r;
        int unsigned sw;
        logic        is_press;
        r.status  = STATUS_OK;
        r.pressed = 1'b0;
        if (s.switch_index >= NUM_SW)
        begin
            r.status = STATUS_BAD_INDEX;
            return r;
        end
        sw       = 32'(s.switch_index);
        is_press = (s.pin_level == model_mask[sw]);
        if (sw_bouncing[sw])
        begin
            if (is_press)
            begin
                sw_press_cnt[sw] = sw_press_cnt[sw] + COUNT_W'(1);
                sw_rel_cnt[sw]   = '0;
            end
            else
            begin
                sw_rel_cnt[sw]   = sw_rel_cnt[sw] + COUNT_W'(1);
                sw_press_cnt[sw] = '0;
            end
            // pressed counter is tested first
            if (sw_press_cnt[sw] == model_limit)
            begin
                sw_press_cnt[sw] = '0;
                sw_bouncing[sw]  = 1'b0;
                sw_stable[sw]    = 1'b1;
            end
            else if (sw_rel_cnt[sw] == model_limit)
            begin
                sw_rel_cnt[sw]  = '0;
                sw_bouncing[sw] = 1'b0;
                sw_stable[sw]   = 1'b0;
            end
            r.pressed = sw_stable[sw];
        end
        else
        begin
            // report the old state; counters keep their values
            r.pressed = sw_stable[sw];
            if (is_press != sw_stable[sw])
                sw_bouncing[sw] = 1'b1;
        end
        return r;
    endfunction

    // Called at a rising edge; returns at a rising edge
    task automatic send_sample(input logic [INDEX_W-1:0] idx, input logic lvl);
        sample_t s;
        s.switch_index = idx;
        s.pin_level    = lvl;
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (sample_stall);
        expected_results.push_back(debounce_predict(s));
        n_sent++;
        if (tx_idle_on && $urandom_range(0, 99) < 25)
        begin
            sample_valid <= 1'b0;
            repeat (rand_gap()) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_IDX_COUNT_LIMIT: model_limit = data[COUNT_W-1:0];
            CFG_IDX_LEVEL_MASK:  model_mask  = data[MASK_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Limit write with junk in the unused upper byte
    task automatic write_limit(input logic [COUNT_W-1:0] lim);
        logic [CFG_DATA_W-COUNT_W-1:0] junk;
        junk = (CFG_DATA_W-COUNT_W)'($urandom_range(0, 255));
        write_reg(CFG_IDX_COUNT_LIMIT, {junk, lim});
    endtask

    task automatic test_bad_index();
        send_sample(INDEX_W'(NUM_SW), 1'b1);
        send_sample('1, 1'b0);
        send_sample(8'h80, 1'b1);
        send_sample(8'h7F, 1'b0);
    endtask

    task automatic test_reset_defaults();
        // mask clear: level 0 means pressed, so this starts a bounce
        send_sample(8'd0, 1'b0);
        send_sample(INDEX_W'(NUM_SW - 1), 1'b1);
    endtask

    task automatic test_press_release();
        wait_drained();
        write_limit(8'd2);
        write_reg(CFG_IDX_LEVEL_MASK, 16'h8001);
        send_sample(8'd0, 1'b1);
        send_sample(8'd0, 1'b0);
        send_sample(8'd0, 1'b1);
        send_sample(8'd0, 1'b1);
        send_sample(8'd0, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(INDEX_W'(NUM_SW - 1), 1'b0);
        send_sample(INDEX_W'(NUM_SW - 1), 1'b1);
        send_sample(INDEX_W'(NUM_SW - 1), 1'b1);
        send_sample(INDEX_W'(NUM_SW - 1), 1'b0);
        send_sample(INDEX_W'(NUM_SW - 1), 1'b1);
    endtask

    task automatic test_limit_zero();
        wait_drained();
        write_limit(8'd0);
        // switch 3 presses at level 0: each bouncing word takes the opposite level
        send_sample(8'd3, 1'b0);
        send_sample(8'd3, 1'b0);
        send_sample(8'd3, 1'b1);
        send_sample(8'd3, 1'b0);
        send_sample(8'd3, 1'b1);
    endtask

    task automatic test_unknown_register();
        wait_drained();
        write_reg(CFG_IDX_SPARE_LO, 16'hFFFF);
        write_reg(CFG_IDX_SPARE_HI, 16'h0000);
        send_sample(8'd9, 1'b0);
        send_sample(8'd9, 1'b0);
    endtask

    task automatic test_counter_wrap();
        logic press;
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        write_limit(8'd200);
        press = model_mask[5];
        while (!(sw_bouncing[5] && sw_press_cnt[5] == 8'd150))
        begin
            send_sample(8'd5, press);
            if ($urandom_range(0, 9) == 0)
                send_sample(rand_index(0, 4), rand_level());
        end
        // lower the limit under the count: it must wrap before matching
        wait_drained();
        write_limit(8'd100);
        while (sw_bouncing[5])
        begin
            send_sample(8'd5, press);
            if ($urandom_range(0, 9) == 0)
                send_sample(rand_index(0, 4), rand_level());
        end
    endtask

    task automatic test_pressed_wins_at_wrap();
        logic press;
        wait_drained();
        write_limit(8'd255);
        press = model_mask[6];
        while (!(sw_bouncing[6] && sw_press_cnt[6] == 8'd254))
            send_sample(8'd6, press);
        wait_drained();
        write_limit(8'd0);
        // 255: released counter wins; then re-bounce; then 0: pressed wins
        send_sample(8'd6, press);
        send_sample(8'd6, press);
        send_sample(8'd6, press);
    endtask

    task automatic test_backpressure();
        wait_drained();
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_off_len = HOLD_OFF_LEN;
        repeat (40) send_sample(rand_index(0, NUM_SW - 1), rand_level());
    endtask

    task automatic send_burst();
        logic [INDEX_W-1:0] idx;
        logic               lvl;
        int unsigned        len;
        if ($urandom_range(0, 99) < 8)
        begin
            send_sample(rand_index(NUM_SW, 255), rand_level());
            return;
        end
        idx = rand_index(0, NUM_SW - 1);
        lvl = rand_level();
        // chatter, then a steady run of up to the limit plus two words, at most 12
        repeat ($urandom_range(0, 3)) send_sample(idx, rand_level());
        if (model_limit > 12)
            len = $urandom_range(1, 12);
        else
            len = $urandom_range(1, model_limit + 2);
        repeat (len) send_sample(idx, lvl);
    endtask

    task automatic test_random_phases();
        int unsigned        phase_end;
        logic [COUNT_W-1:0] lim;
        logic [MASK_W-1:0]  msk;
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            case (ph)
                0:       lim = 8'd1;
                1:       lim = 8'd255;
                4:       lim = 8'd0;
                default: lim = COUNT_W'($urandom_range(1, 6));
            endcase
            case (ph)
                0:       msk = '0;
                1:       msk = '1;
                default: msk = MASK_W'($urandom_range(0, 65535));
            endcase
            write_limit(lim);
            write_reg(CFG_IDX_LEVEL_MASK, msk);
            tx_idle_on = (ph % 3 != 0);
            rx_idle_on = (ph % 4 != 1);
            phase_end  = n_sent + 140;
            while (n_sent < phase_end)
                send_burst();
        end
    endtask

    // Result side stalls
    initial
    begin
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
                result_stall <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 99) < 20)
            begin
                result_stall <= 1'b1;
                repeat (rand_gap()) @(posedge clk);
                result_stall <= 1'b0;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result word: status %0b pressed %0b",
                       result.status, result.pressed);
                n_fail++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0b, got %0b", want.status, result.status);
                    n_fail++;
                end
                if (result.pressed !== want.pressed)
                begin
                    $error("pressed: expected %0b, got %0b", want.pressed, result.pressed);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || cfg_wr_en)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        idle_cycles  = 0;
        hold_off_len = 0;
        n_sent       = 0;
        n_fail       = 0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        model_limit  = COUNT_LIMIT_RESET;
        model_mask   = MASK_RESET;
        for (int i = 0; i < MAX_SWITCHES; i++)
        begin
            sw_stable[i]    = 1'b0;
            sw_bouncing[i]  = 1'b0;
            sw_press_cnt[i] = '0;
            sw_rel_cnt[i]   = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bad_index();
        test_reset_defaults();
        test_press_release();
        test_limit_zero();
        test_unknown_register();
        test_counter_wrap();
        test_pressed_wins_at_wrap();
        test_backpressure();
        test_random_phases();
        wait_drained();

        if (n_fail == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
